FILE: rtl/ttsp_pkg.sv
// ----------------------------------------------------------------------------
// Ternary token serial port package
// Shared types, transaction codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttsp_pkg;

  localparam int RING_DEPTH_DEF  = 27;
  localparam int TRITS_PER_TRYTE = 6;
  localparam int TRYTE_W         = 2 * TRITS_PER_TRYTE;
  localparam int CNT_W           = $clog2(TRITS_PER_TRYTE);

  localparam logic [7:0] CHAR_L = 8'h6C;
  localparam logic [7:0] CHAR_T = 8'h74;
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_U = 8'h75;

  localparam logic [1:0] TRIT_LA   = 2'd0;
  localparam logic [1:0] TRIT_LI   = 2'd1;
  localparam logic [1:0] TRIT_LU   = 2'd2;
  localparam logic [1:0] TRIT_BAD  = 2'd3;
  localparam logic [1:0] FLAG_SET  = 2'd2;
  localparam logic [1:0] FLAG_NONE = 2'd0;

  typedef enum logic [1:0] {
    FUNC_TOKEN = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  token_first;
    logic [7:0]  token_second;
    logic [11:0] write_tryte;
  } item_t;

  typedef struct packed {
    logic [11:0] read_tryte;
    logic        tx_valid;
    logic [1:0]  tx_trit;
    logic [1:0]  has_input;
    logic [1:0]  has_output;
  } result_t;

endpackage

FILE: rtl/ttsp_ring_mem.sv
// ----------------------------------------------------------------------------
// Ring memory
// Synchronous single-read, single-write memory with per-entry valid flags so
// that every entry reads as zero after reset until it is first written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttsp_ring_mem #(
  parameter int DEPTH = 27,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

FILE: rtl/ternary_token_serial_port_unit.sv
// ----------------------------------------------------------------------------
// Ternary token serial port unit
// Receive and transmit rings of trytes with trit-serial token handling.
// ----------------------------------------------------------------------------
// The item channel carries one transaction per token, transmit tick, host read
// or host write, selected by func. Every transaction yields exactly one result
// on the result channel, carrying the read tryte, the transmitted trit and the
// two status flags as they stand after the transaction.
// Both rings live in synchronous memories with registered read data. An
// accepted transaction reads its ring entry in the accept cycle and modifies
// and writes it back in the execute state, when the result is loaded into
// the output register. Result valid rises as the result is loaded, and the
// unit takes no new transaction until the current one is done, set by this
// read-modify-write pass through the ring memories.
// When the receiver stalls, a finished result waits in the output register;
// one further transaction is accepted and then held before write-back until
// the output register is free.
// Reset clears the pointers, trit counts and the valid flags of both rings,
// so every ring entry reads as zero until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ternary_token_serial_port_unit
  import ttsp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  state_t state, state_next;
  item_t  cur_item;

  logic [PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [CNT_W-1:0] rx_count, rx_count_next, tx_count, tx_count_next;

  logic               accept, done;
  logic               rx_we, tx_we;
  logic [PTR_W-1:0]   rx_waddr, tx_waddr, rx_raddr;
  logic [TRYTE_W-1:0] rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  logic [1:0]         trit, gone;
  logic               trit_ok;
  result_t            result_next;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign accept   = item_valid && item_ready;
  assign rx_raddr = (item.func == FUNC_READ) ? rx_head : rx_tail;

  ttsp_ring_mem #(
    .DEPTH(RING_DEPTH),
    .WIDTH(TRYTE_W)
  ) u_rx_ring (
    .clk  (clk),
    .rst  (rst),
    .we   (rx_we),
    .waddr(rx_waddr),
    .wdata(rx_wdata),
    .re   (accept),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  ttsp_ring_mem #(
    .DEPTH(RING_DEPTH),
    .WIDTH(TRYTE_W)
  ) u_tx_ring (
    .clk  (clk),
    .rst  (rst),
    .we   (tx_we),
    .waddr(tx_waddr),
    .wdata(tx_wdata),
    .re   (accept),
    .raddr(tx_head),
    .rdata(tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      rx_count     <= '0;
      tx_count     <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rx_head  <= rx_head_next;
      rx_tail  <= rx_tail_next;
      tx_head  <= tx_head_next;
      tx_tail  <= tx_tail_next;
      rx_count <= rx_count_next;
      tx_count <= tx_count_next;
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_item <= item;
    end
    if (done) begin
      result <= result_next;
    end
  end

  always_comb begin
    case (cur_item.token_second)
      CHAR_A:  begin trit = TRIT_LA; trit_ok = 1'b1; end
      CHAR_I:  begin trit = TRIT_LI; trit_ok = 1'b1; end
      CHAR_U:  begin trit = TRIT_LU; trit_ok = 1'b1; end
      default: begin trit = TRIT_LA; trit_ok = 1'b0; end
    endcase
  end

  assign gone = tx_rdata[TRYTE_W-1 -: 2];

  always_comb begin
    state_next    = state;
    item_ready    = 1'b0;
    done          = 1'b0;
    rx_head_next  = rx_head;
    rx_tail_next  = rx_tail;
    tx_head_next  = tx_head;
    tx_tail_next  = tx_tail;
    rx_count_next = rx_count;
    tx_count_next = tx_count;
    rx_we         = 1'b0;
    rx_waddr      = rx_tail;
    rx_wdata      = {rx_rdata[TRYTE_W-3:0], trit};
    tx_we         = 1'b0;
    tx_waddr      = tx_head;
    tx_wdata      = {tx_rdata[TRYTE_W-3:0], 2'b00};
    result_next   = '0;

    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!result_valid || result_ready) begin
          done       = 1'b1;
          state_next = ST_IDLE;
          case (cur_item.func)
            FUNC_TOKEN: begin
              if (cur_item.token_first == CHAR_L && trit_ok) begin
                rx_we = 1'b1;
                if (rx_count == CNT_W'(TRITS_PER_TRYTE - 1)) begin
                  rx_count_next = '0;
                  rx_tail_next  = next_ptr(rx_tail);
                end else begin
                  rx_count_next = rx_count + 1'b1;
                end
              end else if (cur_item.token_first == CHAR_T &&
                           (cur_item.token_second == CHAR_A ||
                            cur_item.token_second == CHAR_U)) begin
                rx_count_next = '0;
              end
            end
            FUNC_TICK: begin
              if (tx_head != tx_tail) begin
                tx_we = 1'b1;
                if (gone != TRIT_BAD) begin
                  result_next.tx_valid = 1'b1;
                  result_next.tx_trit  = gone;
                end
                if (tx_count == CNT_W'(TRITS_PER_TRYTE - 1)) begin
                  tx_count_next = '0;
                  tx_head_next  = next_ptr(tx_head);
                end else begin
                  tx_count_next = tx_count + 1'b1;
                end
              end
            end
            FUNC_READ: begin
              result_next.read_tryte = rx_rdata;
              rx_head_next           = next_ptr(rx_head);
            end
            FUNC_WRITE: begin
              tx_we        = 1'b1;
              tx_waddr     = tx_tail;
              tx_wdata     = cur_item.write_tryte;
              tx_tail_next = next_ptr(tx_tail);
            end
            default: begin
            end
          endcase
          result_next.has_input  = (rx_head_next == rx_tail_next || rx_count_next != '0)
                                   ? FLAG_NONE : FLAG_SET;
          result_next.has_output = (tx_head_next == tx_tail_next) ? FLAG_NONE : FLAG_SET;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("Accepted transaction did not enter execution.");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    done |=> result_valid)
    else $error("Finished transaction produced no result.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rx_we && !tx_we)
    else $error("Ring memory written outside execution.");

  a_counts_range: assert property (@(posedge clk) disable iff (rst)
    rx_count < CNT_W'(TRITS_PER_TRYTE) && tx_count < CNT_W'(TRITS_PER_TRYTE))
    else $error("Trit count out of range.");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rx_head} < (PTR_W + 1)'(RING_DEPTH) &&
    {1'b0, rx_tail} < (PTR_W + 1)'(RING_DEPTH) &&
    {1'b0, tx_head} < (PTR_W + 1)'(RING_DEPTH) &&
    {1'b0, tx_tail} < (PTR_W + 1)'(RING_DEPTH))
    else $error("Ring pointer out of range.");
`endif

endmodule

FILE: test/ternary_token_serial_port_check.sv
// ----------------------------------------------------------------------------
// Ternary token serial port checker
// Watches both channels of the serial port unit. It keeps its own copy of
// the receive and send rings and computes the result of every accepted
// transaction. Each result is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ternary_token_serial_port_check
  import ttsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      errors,
  output int      pending
);

  localparam int PTR_W = $clog2(RING_DEPTH_DEF);

  logic [TRYTE_W-1:0] rx_ring [RING_DEPTH_DEF];
  logic [TRYTE_W-1:0] tx_ring [RING_DEPTH_DEF];
  logic [PTR_W-1:0]   rx_head, rx_tail, tx_head, tx_tail;
  int                 rx_count, tx_count;

  result_t due_results [$];
  int      mismatches = 0;
  int      waiting = 0;

  assign errors  = mismatches;
  assign pending = waiting;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH_DEF - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic result_t next_port_result(input item_t it);
    result_t    r;
    logic [1:0] trit;
    logic [1:0] gone;
    r = '0;
    case (it.func)
      FUNC_TOKEN: begin
        if (it.token_first == CHAR_L && (it.token_second == CHAR_A ||
            it.token_second == CHAR_I || it.token_second == CHAR_U)) begin
          trit = (it.token_second == CHAR_A) ? TRIT_LA :
                 (it.token_second == CHAR_I) ? TRIT_LI : TRIT_LU;
          rx_ring[rx_tail] = {rx_ring[rx_tail][TRYTE_W-3:0], trit};
          if (rx_count == TRITS_PER_TRYTE - 1) begin
            rx_count = 0;
            rx_tail  = wrap_next(rx_tail);
          end else begin
            rx_count++;
          end
        end else if (it.token_first == CHAR_T &&
                     (it.token_second == CHAR_A || it.token_second == CHAR_U)) begin
          rx_count = 0;
        end
      end
      FUNC_TICK: begin
        if (tx_head != tx_tail) begin
          gone = tx_ring[tx_head][TRYTE_W-1 -: 2];
          tx_ring[tx_head] = {tx_ring[tx_head][TRYTE_W-3:0], TRIT_LA};
          if (gone != TRIT_BAD) begin
            r.tx_valid = 1'b1;
            r.tx_trit  = gone;
          end
          tx_count++;
          if (tx_count == TRITS_PER_TRYTE) begin
            tx_count = 0;
            tx_head  = wrap_next(tx_head);
          end
        end
      end
      FUNC_READ: begin
        r.read_tryte = rx_ring[rx_head];
        rx_head      = wrap_next(rx_head);
      end
      FUNC_WRITE: begin
        tx_ring[tx_tail] = it.write_tryte;
        tx_tail          = wrap_next(tx_tail);
      end
      default: ;
    endcase
    r.has_input  = (rx_head == rx_tail || rx_count != 0) ? FLAG_NONE : FLAG_SET;
    r.has_output = (tx_head == tx_tail) ? FLAG_NONE : FLAG_SET;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      k;
    if (rst) begin
      for (k = 0; k < RING_DEPTH_DEF; k++) begin
        rx_ring[k] = '0;
        tx_ring[k] = '0;
      end
      rx_head  = '0;
      rx_tail  = '0;
      tx_head  = '0;
      tx_tail  = '0;
      rx_count = 0;
      tx_count = 0;
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result transaction with none due: rd=%h txv=%b trit=%0d in=%0d out=%0d",
                     $realtime, result.read_tryte, result.tx_valid, result.tx_trit,
                     result.has_input, result.has_output);
          end
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (want.read_tryte !== result.read_tryte || want.tx_valid !== result.tx_valid ||
              want.tx_trit !== result.tx_trit || want.has_input !== result.has_input ||
              want.has_output !== result.has_output) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected rd=%h txv=%b trit=%0d in=%0d out=%0d",
                       $realtime, want.read_tryte, want.tx_valid, want.tx_trit,
                       want.has_input, want.has_output);
              $display("%0t:           actual   rd=%h txv=%b trit=%0d in=%0d out=%0d",
                       $realtime, result.read_tryte, result.tx_valid, result.tx_trit,
                       result.has_input, result.has_output);
            end
            mismatches++;
          end
        end
      end
      if (item_valid && item_ready) begin
        due_results.push_back(next_port_result(item));
      end
    end
    waiting <= due_results.size();
  end

endmodule

FILE: test/ternary_token_serial_port_unit_test.sv
// ----------------------------------------------------------------------------
// Ternary token serial port unit testbench
// Drives tokens, transmit ticks and host accesses into the unit, first a
// directed sequence and then random segments that fill and drain the rings,
// with random gaps on both channels. The checker beside the unit predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ternary_token_serial_port_unit_test;
  import ttsp_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      errors;
  int      pending;
  bit      calm = 1'b0;

  ternary_token_serial_port_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  ternary_token_serial_port_check check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  task automatic issue(input func_t f, input logic [7:0] c1, input logic [7:0] c2,
                       input logic [11:0] w);
    int unsigned gap;
    item_t       it;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func         = f;
    it.token_first  = c1;
    it.token_second = c2;
    it.write_tryte  = w;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Profiles: 0 balanced, 1 fills the send ring, 2 drains it,
  // 3 floods the receive ring with no reads, 4 drains the receive ring.
  function automatic item_t draw_item(input int unsigned profile);
    item_t       it;
    int unsigned pick, shape, good, lim_tok, lim_tick, lim_read;
    it.func         = FUNC_TOKEN;
    it.token_first  = 8'($urandom_range(0, 255));
    it.token_second = 8'($urandom_range(0, 255));
    it.write_tryte  = 12'($urandom_range(0, 4095));
    good = 78;
    case (profile)
      1: begin lim_tok = 20; lim_tick = 30; lim_read = 40; end
      2: begin lim_tok = 20; lim_tick = 80; lim_read = 90; end
      3: begin lim_tok = 96; lim_tick = 98; lim_read = 98; good = 94; end
      4: begin lim_tok = 40; lim_tick = 45; lim_read = 95; end
      default: begin lim_tok = 45; lim_tick = 70; lim_read = 80; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < lim_tok) begin
      shape = $urandom_range(0, 99);
      if (shape < good) begin
        it.token_first = CHAR_L;
        case ($urandom_range(0, 2))
          0:       it.token_second = CHAR_A;
          1:       it.token_second = CHAR_I;
          default: it.token_second = CHAR_U;
        endcase
      end else if (shape < good + 2) begin
        it.token_first  = CHAR_T;
        it.token_second = $urandom_range(0, 1) ? CHAR_A : CHAR_U;
      end else if (shape < good + 4) begin
        it.token_first = CHAR_L;
      end else if (shape < good + 6) begin
        it.token_first = CHAR_T;
      end
    end else if (pick < lim_tick) begin
      it.func = FUNC_TICK;
    end else if (pick < lim_read) begin
      it.func = FUNC_READ;
    end else begin
      it.func = FUNC_WRITE;
    end
    return it;
  endfunction

  initial begin
    int          sent;
    int          seg_len;
    int          k;
    int unsigned profile;
    item_t       it;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Read and tick on empty rings.
    issue(FUNC_READ, 8'h00, 8'h00, 12'h000);
    issue(FUNC_TICK, 8'hFF, 8'hFF, 12'hFFF);
    // Partial tryte, then a restart, then a full tryte over the same entry.
    issue(FUNC_TOKEN, CHAR_L, CHAR_U, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_I, 12'h000);
    issue(FUNC_TOKEN, CHAR_T, CHAR_A, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_A, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_I, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_U, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_U, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_I, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, CHAR_A, 12'h000);
    // Restart on a complete tryte, then tokens that are ignored.
    issue(FUNC_TOKEN, CHAR_T, CHAR_U, 12'h000);
    issue(FUNC_TOKEN, CHAR_T, CHAR_I, 12'h000);
    issue(FUNC_TOKEN, CHAR_L, 8'hFF, 12'h000);
    issue(FUNC_TOKEN, 8'h00, 8'h00, 12'hFFF);
    issue(FUNC_TOKEN, 8'hFF, 8'hFF, 12'h000);
    issue(FUNC_READ, 8'h00, 8'h00, 12'h000);
    // A tryte of all code three sends nothing but still advances the head.
    issue(FUNC_WRITE, 8'h00, 8'h00, 12'hFFF);
    issue(FUNC_WRITE, 8'hFF, 8'hFF, 12'h000);
    for (k = 0; k < 7; k++) begin
      issue(FUNC_TICK, 8'h00, 8'h00, 12'h000);
    end

    sent = 0;
    profile = 3;
    seg_len = 220;
    while (sent < 650) begin
      calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < seg_len; k++) begin
        it = draw_item(profile);
        issue(it.func, it.token_first, it.token_second, it.write_tryte);
      end
      sent += seg_len;
      profile = $urandom_range(0, 4);
      seg_len = $urandom_range(30, 80);
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ttsp_pkg.sv
rtl/ttsp_ring_mem.sv
rtl/ternary_token_serial_port_unit.sv
test/ternary_token_serial_port_check.sv
test/ternary_token_serial_port_unit_test.sv
